[hdl/dsem_pkg.sv]
// Package for the debounced spool and endstop monitor.
// Holds the opcode and register index codes, reset windows and the result type.
// No dependencies.
`timescale 1ns / 1ps

package dsem_pkg;

  localparam int unsigned WIN_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [WIN_W-1:0] HALL_WINDOW_RESET    = 32'd5000;
  localparam logic [WIN_W-1:0] ENDSTOP_WINDOW_RESET = 32'd20000;

  localparam logic [CFG_IDX_W-1:0] REG_HALL_WINDOW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_WINDOW = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_HALL_EDGE   = 3'd0,
    OP_LEFT_EDGE   = 3'd1,
    OP_RIGHT_EDGE  = 3'd2,
    OP_READ_COUNT  = 3'd3,
    OP_READ_CLEAR  = 3'd4,
    OP_QUERY_LEFT  = 3'd5,
    OP_QUERY_RIGHT = 3'd6
  } op_e;

  // Packed from the top bit down; edge_accepted sits in bit 0.
  typedef struct packed {
    logic             flag_value;
    logic [CNT_W-1:0] total_value;
    logic [CNT_W-1:0] count_value;
    logic             event_side;
    logic             endstop_event;
    logic             edge_accepted;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

[hdl/dsem_lockout.sv]
// Time lockout for one sensor channel: last accepted time and the window test.
// Depends on dsem_pkg.
`timescale 1ns / 1ps

module dsem_lockout #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dsem_pkg::NOW_W-1:0] now_i,
  input  logic [dsem_pkg::WIN_W-1:0] window_i,
  input  logic                      check_i,
  output logic                      pass_o
);
  import dsem_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > WIN_W) ?
                                  ((TIME_BITS > NOW_W) ? TIME_BITS : NOW_W) :
                                  ((WIN_W > NOW_W) ? WIN_W : NOW_W);

  logic [TIME_BITS-1:0] last_q, last_d;
  logic [CMP_W-1:0]     now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;

  assign now_ext = CMP_W'(now_i);
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign elapsed = now_t - last_q;
  assign pass_o  = CMP_W'(elapsed) >= CMP_W'(window_i);

  always_comb begin
    last_d = last_q;
    if (check_i && pass_o) begin
      last_d = now_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

[hdl/debounced_spool_and_endstop_monitor.sv]
// Debounced spool and endstop monitor: hall and two endstop lockouts, counters, flags.
// An item is held in the input register, then in the result register.
// Throughput: one item per cycle while the sink does not stall;
// the single-pass subtract and compare sets the pace.
// Reset (async, active low) clears times, counters, flags and valid bits and loads
// the hall window with 5000 us and the endstop window with 20000 us.
// Depends on dsem_pkg and dsem_lockout.
`timescale 1ns / 1ps

module debounced_spool_and_endstop_monitor #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dsem_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsem_pkg::WIN_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dsem_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] now_us
  input  logic [dsem_pkg::OP_W-1:0]          s_axis_tuser,  // [2:0] opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] edge_accepted, [1] endstop_event, [2] event_side, [34:3] count_value,
  // [66:35] total_value, [67] flag_value, [71:68] zero
  output logic [dsem_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import dsem_pkg::*;

  logic             in_valid_q, in_valid_d;
  op_e              in_op_q;
  logic [NOW_W-1:0] in_now_q;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic [WIN_W-1:0] hall_win_q, endstop_win_q;
  logic [CNT_W-1:0] win_cnt_q, win_cnt_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             left_flag_q, left_flag_d;
  logic             right_flag_q, right_flag_d;

  logic fire;
  logic in_take;
  logic hall_chk, left_chk, right_chk;
  logic hall_pass, left_pass, right_pass;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign hall_chk  = fire && (in_op_q == OP_HALL_EDGE);
  assign left_chk  = fire && (in_op_q == OP_LEFT_EDGE);
  assign right_chk = fire && (in_op_q == OP_RIGHT_EDGE);

  dsem_lockout #(.TIME_BITS(TIME_BITS)) u_hall (
    .clk_i, .rst_ni, .now_i(in_now_q), .window_i(hall_win_q),
    .check_i(hall_chk), .pass_o(hall_pass)
  );

  dsem_lockout #(.TIME_BITS(TIME_BITS)) u_left (
    .clk_i, .rst_ni, .now_i(in_now_q), .window_i(endstop_win_q),
    .check_i(left_chk), .pass_o(left_pass)
  );

  dsem_lockout #(.TIME_BITS(TIME_BITS)) u_right (
    .clk_i, .rst_ni, .now_i(in_now_q), .window_i(endstop_win_q),
    .check_i(right_chk), .pass_o(right_pass)
  );

  always_comb begin
    win_cnt_d    = win_cnt_q;
    total_d      = total_q;
    left_flag_d  = left_flag_q;
    right_flag_d = right_flag_q;
    res_d        = '0;
    case (in_op_q)
      OP_HALL_EDGE: begin
        if (hall_pass) begin
          win_cnt_d           = win_cnt_q + 1'b1;
          total_d             = total_q + 1'b1;
          res_d.edge_accepted = 1'b1;
        end
      end
      OP_LEFT_EDGE: begin
        if (left_pass) begin
          left_flag_d         = 1'b1;
          res_d.edge_accepted = 1'b1;
          res_d.endstop_event = 1'b1;
        end
      end
      OP_RIGHT_EDGE: begin
        if (right_pass) begin
          right_flag_d        = 1'b1;
          res_d.edge_accepted = 1'b1;
          res_d.endstop_event = 1'b1;
          res_d.event_side    = 1'b1;
        end
      end
      OP_READ_COUNT: begin
        res_d.count_value = win_cnt_q;
      end
      OP_READ_CLEAR: begin
        res_d.count_value = win_cnt_q;
        win_cnt_d         = '0;
      end
      OP_QUERY_LEFT: begin
        res_d.flag_value = left_flag_q;
        left_flag_d      = 1'b0;
      end
      OP_QUERY_RIGHT: begin
        res_d.flag_value = right_flag_q;
        right_flag_d     = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.total_value = total_d;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      hall_win_q    <= HALL_WINDOW_RESET;
      endstop_win_q <= ENDSTOP_WINDOW_RESET;
      win_cnt_q     <= '0;
      total_q       <= '0;
      left_flag_q   <= 1'b0;
      right_flag_q  <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == REG_HALL_WINDOW)) begin
        hall_win_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_ENDSTOP_WINDOW)) begin
        endstop_win_q <= cfg_wdata_i;
      end
      if (fire) begin
        win_cnt_q    <= win_cnt_d;
        total_q      <= total_d;
        left_flag_q  <= left_flag_d;
        right_flag_q <= right_flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= op_e'(s_axis_tuser);
      in_now_q <= s_axis_tdata[NOW_W-1:0];
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_q};

endmodule

[hdl/dsem_checker.sv]
// Port-level checks for the debounced spool and endstop monitor, bound to the top level.
// Depends on dsem_pkg and debounced_spool_and_endstop_monitor.
`timescale 1ns / 1ps

module dsem_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dsem_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dsem_pkg::*;

  // Held result stays put while the sink stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_event_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("endstop event without accepted edge");

  a_side_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[2] || m_axis_tdata[1]))
    else $error("event side set without endstop event");

  // Reads and edges are different items, so their fields never mix.
  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((!m_axis_tdata[67] || (m_axis_tdata[34:3] == '0)) &&
                       (!m_axis_tdata[0] || (!m_axis_tdata[67] &&
                                             (m_axis_tdata[34:3] == '0)))))
    else $error("read and edge fields both set");

endmodule

bind debounced_spool_and_endstop_monitor dsem_checker u_dsem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/debounced_spool_and_endstop_monitor_tb.sv]
// Self-checking bench for the spool and endstop monitor: an in-bench lockout model predicts
// every report, with random stream stalls and window register changes between phases.
// Depends on dsem_pkg and the debounced_spool_and_endstop_monitor RTL.
`timescale 1ns / 1ps

module debounced_spool_and_endstop_monitor_tb;
  import dsem_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 3'd7;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 48;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NOW_W-1:0] now;
  } sample_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [WIN_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [31:0] now_us
  logic [OP_W-1:0]        s_axis_tuser = '0;  // [2:0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] edge_accepted, [1] endstop_event, [2] event_side, [34:3] count_value,
  // [66:35] total_value, [67] flag_value, [71:68] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  debounced_spool_and_endstop_monitor u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // lockout model state
  logic [WIN_W-1:0] hall_win_m = HALL_WINDOW_RESET;
  logic [WIN_W-1:0] stop_win_m = ENDSTOP_WINDOW_RESET;
  logic [NOW_W-1:0] last_hall = '0;
  logic [NOW_W-1:0] last_left = '0;
  logic [NOW_W-1:0] last_right = '0;
  logic [CNT_W-1:0] pulse_win = '0;
  logic [CNT_W-1:0] pulse_tot = '0;
  logic             left_hit = 1'b0;
  logic             right_hit = 1'b0;

  sample_t     sample_q[$];
  res_t        report_q[$];
  int          err_cnt = 0;
  int          quiet = 0;
  bit          in_taken = 1'b0;
  bit          jitter_on = 1'b1;
  bit          hold_arm = 1'b0;
  int          hold_cnt = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  logic [31:0] stamp = '0;

  function automatic res_t monitor_step(logic [OP_W-1:0] op, logic [NOW_W-1:0] now);
    res_t             r;
    logic [NOW_W-1:0] dt_hall, dt_left, dt_right;
    r = '0;
    dt_hall  = now - last_hall;
    dt_left  = now - last_left;
    dt_right = now - last_right;
    case (op)
      OP_HALL_EDGE: begin
        if (dt_hall >= hall_win_m) begin
          last_hall = now;
          pulse_win = pulse_win + 1'b1;
          pulse_tot = pulse_tot + 1'b1;
          r.edge_accepted = 1'b1;
        end
      end
      OP_LEFT_EDGE: begin
        if (dt_left >= stop_win_m) begin
          last_left = now;
          left_hit = 1'b1;
          r.edge_accepted = 1'b1;
          r.endstop_event = 1'b1;
        end
      end
      OP_RIGHT_EDGE: begin
        if (dt_right >= stop_win_m) begin
          last_right = now;
          right_hit = 1'b1;
          r.edge_accepted = 1'b1;
          r.endstop_event = 1'b1;
          r.event_side = 1'b1;
        end
      end
      OP_READ_COUNT: r.count_value = pulse_win;
      OP_READ_CLEAR: begin
        r.count_value = pulse_win;
        pulse_win = '0;
      end
      OP_QUERY_LEFT: begin
        r.flag_value = left_hit;
        left_hit = 1'b0;
      end
      OP_QUERY_RIGHT: begin
        r.flag_value = right_hit;
        right_hit = 1'b0;
      end
      default: ;
    endcase
    r.total_value = pulse_tot;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // input accept, report check and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    res_t want, got;
    if (rst_ni) begin
      quiet++;
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(monitor_step(s_axis_tuser, s_axis_tdata));
        in_taken = 1'b1;
        quiet = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet = 0;
        got = m_axis_tdata[RES_W-1:0];
        if (report_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0h", $time, m_axis_tdata);
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("edge_accepted", want.edge_accepted, got.edge_accepted);
          check_field("endstop_event", want.endstop_event, got.endstop_event);
          check_field("event_side", want.event_side, got.event_side);
          check_field("count_value", want.count_value, got.count_value);
          check_field("total_value", want.total_value, got.total_value);
          check_field("flag_value", want.flag_value, got.flag_value);
          check_field("pad", '0, m_axis_tdata[OUT_TDATA_W-1:RES_W]);
        end
      end
      if (cfg_we_i) quiet = 0;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // sensor item driver
  always @(negedge clk_i) begin
    sample_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        nxt = sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.now;
        s_axis_tuser  <= nxt.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // report sink with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push(logic [OP_W-1:0] op, logic [NOW_W-1:0] now);
    sample_q.push_back('{op: op, now: now});
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) @(negedge clk_i);
  endtask

  // call at a falling edge with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_HALL_WINDOW) hall_win_m = val;
    else stop_win_m = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_random(int n);
    logic [31:0]     span_h, span_e;
    logic [OP_W-1:0] op;
    int              sel;
    span_h = (hall_win_m > 100000) ? 100000 : hall_win_m;
    span_e = (stop_win_m > 100000) ? 100000 : stop_win_m;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      op = (sel < 36) ? OP_HALL_EDGE :
           (sel < 48) ? OP_LEFT_EDGE :
           (sel < 60) ? OP_RIGHT_EDGE :
           (sel < 68) ? OP_READ_COUNT :
           (sel < 76) ? OP_READ_CLEAR :
           (sel < 86) ? OP_QUERY_LEFT :
           (sel < 96) ? OP_QUERY_RIGHT : OP_NONE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stamp = stamp + $urandom_range(0, 2 * span_h + 2);
        4, 5, 6:    stamp = stamp + $urandom_range(0, 2 * span_e + 2);
        7:          ;
        8:          stamp = stamp + $urandom;
        default:    stamp = $urandom;
      endcase
      push(op, stamp);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset windows: early edges, exact window boundaries, wrap, flags, unknown opcode
    push(OP_READ_COUNT, 32'd0);
    push(OP_HALL_EDGE, 32'd0);
    push(OP_HALL_EDGE, 32'd4999);
    push(OP_HALL_EDGE, 32'd5000);
    push(OP_LEFT_EDGE, 32'd19999);
    push(OP_LEFT_EDGE, 32'd20000);
    push(OP_RIGHT_EDGE, 32'hFFFF_FFFF);
    push(OP_RIGHT_EDGE, 32'd19998);
    push(OP_RIGHT_EDGE, 32'd19999);
    push(OP_QUERY_LEFT, 32'd0);
    push(OP_QUERY_LEFT, 32'd0);
    push(OP_QUERY_RIGHT, 32'hFFFF_FFFF);
    push(OP_QUERY_RIGHT, 32'd0);
    push(OP_NONE, 32'hFFFF_FFFF);
    push(OP_HALL_EDGE, 32'hFFFF_FFFF);
    push(OP_HALL_EDGE, 32'd4998);
    push(OP_HALL_EDGE, 32'd4999);
    push(OP_READ_CLEAR, 32'd0);
    push(OP_READ_COUNT, 32'hFFFF_FFFF);
    stamp = 32'd30000;
    queue_random(300);
    while (sample_q.size() > 200) @(negedge clk_i);
    hold_arm = 1'b1;
    wait_idle();

    // zero hall window, widest endstop window
    write_reg(REG_HALL_WINDOW, '0);
    write_reg(REG_ENDSTOP_WINDOW, '1);
    push(OP_HALL_EDGE, last_hall);
    push(OP_HALL_EDGE, last_hall);
    push(OP_LEFT_EDGE, last_left + 32'hFFFF_FFFE);
    push(OP_LEFT_EDGE, last_left + 32'hFFFF_FFFF);
    push(OP_RIGHT_EDGE, last_right);
    push(OP_QUERY_LEFT, stamp);
    queue_random(250);
    wait_idle();

    // widest hall window, zero endstop window
    write_reg(REG_HALL_WINDOW, '1);
    write_reg(REG_ENDSTOP_WINDOW, '0);
    push(OP_HALL_EDGE, last_hall + 32'hFFFF_FFFE);
    push(OP_HALL_EDGE, last_hall + 32'hFFFF_FFFF);
    push(OP_RIGHT_EDGE, last_right);
    push(OP_READ_CLEAR, stamp);
    queue_random(200);
    wait_idle();

    write_reg(REG_HALL_WINDOW, $urandom_range(1, 500));
    write_reg(REG_ENDSTOP_WINDOW, $urandom_range(1, 2000));
    queue_random(300);
    wait_idle();

    // steady stream, no stalls
    jitter_on = 1'b0;
    write_reg(REG_HALL_WINDOW, HALL_WINDOW_RESET);
    write_reg(REG_ENDSTOP_WINDOW, $urandom_range(0, 50000));
    queue_random(300);
    wait_idle();
    repeat (4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
